/* rtl/vln_pkg.sv */
// Package for the vector length / normalise unit.
// Opcode codes and fixed Q1.14 constants; no dependencies.
`default_nettype none
package vln_pkg;

  localparam logic [1:0] OP_LENGTH    = 2'd0;
  localparam logic [1:0] OP_SQUARED   = 2'd1;
  localparam logic [1:0] OP_NORMALISE = 2'd2;

  localparam int Q_FRAC = 14;          // Q1.14 fraction bits
  localparam int Q_BITS = Q_FRAC + 1;  // quotient bits, |q| <= 2^14
  localparam int NORM_BITS = 16;       // signed Q1.14 word

endpackage
`default_nettype wire

/* rtl/vector_length_normalize_top.sv */
// Vector length / squared length / Q1.14 normalise unit, fully pipelined.
// A word is taken every cycle the output is free to move; it passes
// through the square and sum front end, the square root pipe, the
// four-lane divider (15 quotient bits) and the output register. A stall
// on the output freezes the whole pipe. Depends on vln_pkg, vln_sumsq,
// vln_isqrt and vln_div.
`default_nettype none
module vector_length_normalize_top #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_opcode,
  input  wire logic [2:0]                in_component_count,
  input  wire logic signed [COMPONENT_BITS-1:0] in_comp_x,
  input  wire logic signed [COMPONENT_BITS-1:0] in_comp_y,
  input  wire logic signed [COMPONENT_BITS-1:0] in_comp_z,
  input  wire logic signed [COMPONENT_BITS-1:0] in_comp_w,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2*COMPONENT_BITS:0]      out_magnitude,
  output logic signed [vln_pkg::NORM_BITS-1:0] out_norm_x,
  output logic signed [vln_pkg::NORM_BITS-1:0] out_norm_y,
  output logic signed [vln_pkg::NORM_BITS-1:0] out_norm_z,
  output logic signed [vln_pkg::NORM_BITS-1:0] out_norm_w,
  output logic                           out_zero_vector
);

  localparam int CB = COMPONENT_BITS;
  localparam int SB = 2 * CB + 1;
  localparam int QB = vln_pkg::Q_BITS;
  localparam int OB = vln_pkg::NORM_BITS;

  logic                 en;
  logic signed [CB-1:0] comp [4];

  logic          a_vld, b_vld, c_vld;
  logic [1:0]    a_opc, b_opc, c_opc;
  logic [SB-1:0] a_s, b_s, c_s;
  logic          a_zero, b_zero, c_zero;
  logic [3:0]    a_neg, b_neg, c_neg;
  logic [CB-1:0] a_abs [4];
  logic [CB-1:0] b_abs [4];
  logic [CB:0]   b_root, c_root;
  logic [QB-1:0] c_quo [4];

  logic          out_valid_r;
  logic [SB-1:0] mag_r, mag_nxt;
  logic [OB-1:0] norm_r [4];
  logic [OB-1:0] norm_nxt [4];
  logic          zero_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign comp[0]  = in_comp_x;
  assign comp[1]  = in_comp_y;
  assign comp[2]  = in_comp_z;
  assign comp[3]  = in_comp_w;

  vln_sumsq #(.CB(CB)) u_sumsq (
    .clk, .rst_n, .en,
    .vld_i(in_valid), .opc_i(in_opcode), .cnt_i(in_component_count), .comp_i(comp),
    .vld_o(a_vld), .opc_o(a_opc), .s_o(a_s), .zero_o(a_zero), .neg_o(a_neg),
    .abs_o(a_abs)
  );

  vln_isqrt #(.CB(CB)) u_isqrt (
    .clk, .rst_n, .en,
    .vld_i(a_vld), .opc_i(a_opc), .s_i(a_s), .zero_i(a_zero), .neg_i(a_neg),
    .abs_i(a_abs),
    .vld_o(b_vld), .opc_o(b_opc), .s_o(b_s), .zero_o(b_zero), .neg_o(b_neg),
    .abs_o(b_abs), .root_o(b_root)
  );

  vln_div #(.CB(CB)) u_div (
    .clk, .rst_n, .en,
    .vld_i(b_vld), .opc_i(b_opc), .s_i(b_s), .zero_i(b_zero), .neg_i(b_neg),
    .abs_i(b_abs), .root_i(b_root),
    .vld_o(c_vld), .opc_o(c_opc), .s_o(c_s), .zero_o(c_zero), .neg_o(c_neg),
    .root_o(c_root), .quo_o(c_quo)
  );

  always_comb begin
    case (c_opc)
      vln_pkg::OP_LENGTH:  mag_nxt = SB'(c_root);
      vln_pkg::OP_SQUARED: mag_nxt = c_s;
      default:             mag_nxt = '0;
    endcase
    for (int l = 0; l < 4; l++) begin
      if (c_opc != vln_pkg::OP_NORMALISE || c_zero) begin
        norm_nxt[l] = '0;
      end else if (c_neg[l]) begin
        norm_nxt[l] = ~OB'(c_quo[l]) + 1'b1;
      end else begin
        norm_nxt[l] = OB'(c_quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_nxt;
      norm_r <= norm_nxt;
      zero_r <= c_zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_magnitude   = mag_r;
  assign out_norm_x      = norm_r[0];
  assign out_norm_y      = norm_r[1];
  assign out_norm_z      = norm_r[2];
  assign out_norm_w      = norm_r[3];
  assign out_zero_vector = zero_r;

endmodule
`default_nettype wire

/* rtl/vln_sumsq.sv */
// Two-stage front end: clamp count, take magnitudes, square, then sum.
// Uses vln_pkg nothing; widths follow CB.
`default_nettype none
module vln_sumsq #(
  parameter int CB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire logic [1:0]           opc_i,
  input  wire logic [2:0]           cnt_i,
  input  wire logic signed [CB-1:0] comp_i [4],
  output logic                      vld_o,
  output logic [1:0]                opc_o,
  output logic [2*CB:0]             s_o,
  output logic                      zero_o,
  output logic [3:0]                neg_o,
  output logic [CB-1:0]             abs_o [4]
);

  localparam int SB = 2 * CB + 1;

  logic [3:0]        use_c;
  logic [CB-1:0]     abs_nxt [4];
  logic [3:0]        neg_nxt;

  logic              vld1_r;
  logic [1:0]        opc1_r;
  logic [3:0]        neg1_r;
  logic [CB-1:0]     abs1_r [4];
  logic [2*CB-1:0]   sq1_r [4];

  logic              vld2_r;
  logic [1:0]        opc2_r;
  logic [3:0]        neg2_r;
  logic [CB-1:0]     abs2_r [4];
  logic [SB-1:0]     s2_r;
  logic [SB-1:0]     s_nxt;

  always_comb begin
    use_c[0] = 1'b1;
    use_c[1] = 1'b1;
    use_c[2] = (cnt_i >= 3'd3);
    use_c[3] = (cnt_i >= 3'd4);
    for (int i = 0; i < 4; i++) begin
      neg_nxt[i] = use_c[i] & comp_i[i][CB-1];
      if (!use_c[i]) begin
        abs_nxt[i] = '0;
      end else if (comp_i[i][CB-1]) begin
        abs_nxt[i] = ~comp_i[i] + 1'b1;
      end else begin
        abs_nxt[i] = comp_i[i];
      end
    end
  end

  always_comb begin
    s_nxt = SB'(sq1_r[0]) + SB'(sq1_r[1]) + SB'(sq1_r[2]) + SB'(sq1_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opc1_r <= opc_i;
      neg1_r <= neg_nxt;
      for (int i = 0; i < 4; i++) begin
        abs1_r[i] <= abs_nxt[i];
        sq1_r[i]  <= abs_nxt[i] * abs_nxt[i];
      end
      opc2_r <= opc1_r;
      neg2_r <= neg1_r;
      abs2_r <= abs1_r;
      s2_r   <= s_nxt;
    end
  end

  assign vld_o  = vld2_r;
  assign opc_o  = opc2_r;
  assign s_o    = s2_r;
  assign zero_o = (s2_r == '0);
  assign neg_o  = neg2_r;
  assign abs_o  = abs2_r;

endmodule
`default_nettype wire

/* rtl/vln_isqrt.sv */
// Pipelined integer square root, one root bit per stage (CB+1 stages).
// Carries the vector payload alongside; no package use.
`default_nettype none
module vln_isqrt #(
  parameter int CB = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire logic [1:0]     opc_i,
  input  wire logic [2*CB:0]  s_i,
  input  wire logic           zero_i,
  input  wire logic [3:0]     neg_i,
  input  wire logic [CB-1:0]  abs_i [4],
  output logic                vld_o,
  output logic [1:0]          opc_o,
  output logic [2*CB:0]       s_o,
  output logic                zero_o,
  output logic [3:0]          neg_o,
  output logic [CB-1:0]       abs_o [4],
  output logic [CB:0]         root_o
);

  localparam int SB = 2 * CB + 1;
  localparam int NB = CB + 1;
  localparam int RB = CB + 1;
  localparam int RW = CB + 3;

  logic           vld_r  [1:NB];
  logic [1:0]     opc_r  [1:NB];
  logic [SB-1:0]  s_r    [1:NB];
  logic           zero_r [1:NB];
  logic [3:0]     neg_r  [1:NB];
  logic [CB-1:0]  abs_r  [1:NB][4];
  logic [RW-1:0]  rem_r  [1:NB];
  logic [RB-1:0]  root_r [1:NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic           vld_c;
    logic [1:0]     opc_c;
    logic [SB-1:0]  s_c;
    logic           zero_c;
    logic [3:0]     neg_c;
    logic [CB-1:0]  abs_c [4];
    logic [RW-1:0]  rem_c;
    logic [RB-1:0]  root_c;
    logic [2*NB-1:0] spad;
    logic [RW-1:0]  rsh;
    logic [RW-1:0]  trial;
    logic           ge;
    logic [RW-1:0]  rem_nxt;
    logic [RB-1:0]  root_nxt;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign opc_c  = opc_i;
      assign s_c    = s_i;
      assign zero_c = zero_i;
      assign neg_c  = neg_i;
      assign abs_c  = abs_i;
      assign rem_c  = '0;
      assign root_c = '0;
    end else begin : g_rest
      assign vld_c  = vld_r[k];
      assign opc_c  = opc_r[k];
      assign s_c    = s_r[k];
      assign zero_c = zero_r[k];
      assign neg_c  = neg_r[k];
      assign abs_c  = abs_r[k];
      assign rem_c  = rem_r[k];
      assign root_c = root_r[k];
    end

    always_comb begin
      spad     = (2*NB)'(s_c);
      rsh      = {rem_c[RW-3:0], spad[2*(NB-1-k) +: 2]};
      trial    = {root_c, 2'b01};
      ge       = (rsh >= trial);
      rem_nxt  = ge ? (rsh - trial) : rsh;
      root_nxt = {root_c[RB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        opc_r[k+1]  <= opc_c;
        s_r[k+1]    <= s_c;
        zero_r[k+1] <= zero_c;
        neg_r[k+1]  <= neg_c;
        abs_r[k+1]  <= abs_c;
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
      end
    end
  end

  assign vld_o  = vld_r[NB];
  assign opc_o  = opc_r[NB];
  assign s_o    = s_r[NB];
  assign zero_o = zero_r[NB];
  assign neg_o  = neg_r[NB];
  assign abs_o  = abs_r[NB];
  assign root_o = root_r[NB];

endmodule
`default_nettype wire

/* rtl/vln_div.sv */
// Four-lane pipelined restoring divider, |c|*2^14 / r, one quotient bit
// per stage. Depends on vln_pkg for the Q1.14 constants.
`default_nettype none
module vln_div #(
  parameter int CB = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_i,
  input  wire logic [1:0]     opc_i,
  input  wire logic [2*CB:0]  s_i,
  input  wire logic           zero_i,
  input  wire logic [3:0]     neg_i,
  input  wire logic [CB-1:0]  abs_i [4],
  input  wire logic [CB:0]    root_i,
  output logic                vld_o,
  output logic [1:0]          opc_o,
  output logic [2*CB:0]       s_o,
  output logic                zero_o,
  output logic [3:0]          neg_o,
  output logic [CB:0]         root_o,
  output logic [vln_pkg::Q_BITS-1:0] quo_o [4]
);

  localparam int SB = 2 * CB + 1;
  localparam int QB = vln_pkg::Q_BITS;
  localparam int NW = CB + 2;

  logic           vld_r  [1:QB];
  logic [1:0]     opc_r  [1:QB];
  logic [SB-1:0]  s_r    [1:QB];
  logic           zero_r [1:QB];
  logic [3:0]     neg_r  [1:QB];
  logic [CB:0]    root_r [1:QB];
  logic [NW-1:0]  rem_r  [1:QB][4];
  logic [QB-1:0]  dl_r   [1:QB][4];
  logic [QB-1:0]  quo_r  [1:QB][4];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic           vld_c;
    logic [1:0]     opc_c;
    logic [SB-1:0]  s_c;
    logic           zero_c;
    logic [3:0]     neg_c;
    logic [CB:0]    root_c;
    logic [NW-1:0]  rem_c [4];
    logic [QB-1:0]  dl_c  [4];
    logic [QB-1:0]  quo_c [4];
    logic [NW-1:0]  rem_nxt [4];
    logic [QB-1:0]  dl_nxt  [4];
    logic [QB-1:0]  quo_nxt [4];

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign opc_c  = opc_i;
      assign s_c    = s_i;
      assign zero_c = zero_i;
      assign neg_c  = neg_i;
      assign root_c = root_i;
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign rem_c[l] = NW'(abs_i[l] >> 1);
        assign dl_c[l]  = {abs_i[l][0], {(QB-1){1'b0}}};
        assign quo_c[l] = '0;
      end
    end else begin : g_rest
      assign vld_c  = vld_r[k];
      assign opc_c  = opc_r[k];
      assign s_c    = s_r[k];
      assign zero_c = zero_r[k];
      assign neg_c  = neg_r[k];
      assign root_c = root_r[k];
      assign rem_c  = rem_r[k];
      assign dl_c   = dl_r[k];
      assign quo_c  = quo_r[k];
    end

    always_comb begin
      logic [NW-1:0] rsh;
      logic          ge;
      for (int l = 0; l < 4; l++) begin
        rsh        = {rem_c[l][NW-2:0], dl_c[l][QB-1]};
        ge         = (rsh >= NW'(root_c));
        rem_nxt[l] = ge ? (rsh - NW'(root_c)) : rsh;
        dl_nxt[l]  = {dl_c[l][QB-2:0], 1'b0};
        quo_nxt[l] = {quo_c[l][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        opc_r[k+1]  <= opc_c;
        s_r[k+1]    <= s_c;
        zero_r[k+1] <= zero_c;
        neg_r[k+1]  <= neg_c;
        root_r[k+1] <= root_c;
        rem_r[k+1]  <= rem_nxt;
        dl_r[k+1]   <= dl_nxt;
        quo_r[k+1]  <= quo_nxt;
      end
    end
  end

  assign vld_o  = vld_r[QB];
  assign opc_o  = opc_r[QB];
  assign s_o    = s_r[QB];
  assign zero_o = zero_r[QB];
  assign neg_o  = neg_r[QB];
  assign root_o = root_r[QB];
  assign quo_o  = quo_r[QB];

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench for vector_length_normalize_top: random and corner vectors,
// predicted length, squared length and Q1.14 normalise checked per word.
// Depends on vln_pkg and the RTL of the block.
`default_nettype none
module testbench;

  typedef struct packed {
    logic [32:0] magnitude;
    logic [15:0] nx, ny, nz, nw;
    logic        zero;
  } vec_result_t;

  class vec_scoreboard;
    vec_result_t pending[$];
    int errors;

    function automatic logic [31:0] root_floor(logic [32:0] s);
      logic [32:0] r;
      logic [32:0] b;
      r = 0;
      for (int i = 16; i >= 0; i--) begin
        b = r | (33'd1 << i);
        if ({31'd0, b} * {31'd0, b} <= {31'd0, s}) r = b;
      end
      return r[31:0];
    endfunction

    function automatic logic [15:0] to_q14(logic signed [15:0] c, logic [31:0] r);
      logic [31:0] a;
      logic [31:0] q;
      a = c < 0 ? -32'(c) : 32'(c);
      q = (a << 14) / r;
      return c < 0 ? 16'(-q) : 16'(q);
    endfunction

    function void note_vector(logic [1:0] op, logic [2:0] cnt,
                              logic signed [15:0] x, y, z, w);
      logic signed [15:0] c[4];
      logic [32:0] s;
      logic [31:0] r;
      vec_result_t e;
      int n;
      n = cnt < 2 ? 2 : (cnt > 4 ? 4 : cnt);
      c[0] = x; c[1] = y; c[2] = n > 2 ? z : 16'sd0; c[3] = n > 3 ? w : 16'sd0;
      s = 0;
      for (int i = 0; i < 4; i++) s += 33'(32'(c[i] * c[i]));
      r = root_floor(s);
      e = '0;
      e.zero = (s == 0);
      if (op == vln_pkg::OP_LENGTH) e.magnitude = 33'(r);
      else if (op == vln_pkg::OP_SQUARED) e.magnitude = s;
      else if (op == vln_pkg::OP_NORMALISE && !e.zero) begin
        e.nx = to_q14(c[0], r); e.ny = to_q14(c[1], r);
        e.nz = to_q14(c[2], r); e.nw = to_q14(c[3], r);
      end
      pending.push_back(e);
    endfunction

    function void check_result(vec_result_t got);
      vec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.magnitude !== e.magnitude) begin
        $display("%0t: magnitude exp %h got %h", $time, e.magnitude, got.magnitude);
        errors++;
      end
      if (got.nx !== e.nx) begin
        $display("%0t: norm_x exp %h got %h", $time, e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: norm_y exp %h got %h", $time, e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: norm_z exp %h got %h", $time, e.nz, got.nz); errors++;
      end
      if (got.nw !== e.nw) begin
        $display("%0t: norm_w exp %h got %h", $time, e.nw, got.nw); errors++;
      end
      if (got.zero !== e.zero) begin
        $display("%0t: zero_vector exp %b got %b", $time, e.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] in_opcode = 0;
  logic [2:0] in_component_count = 2;
  logic signed [15:0] in_comp_x = 0, in_comp_y = 0, in_comp_z = 0, in_comp_w = 0;
  logic in_stall, out_valid, out_zero_vector;
  logic [32:0] out_magnitude;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z, out_norm_w;
  int hold_req = 0;
  logic feeding = 1;
  vec_scoreboard sb = new();

  vector_length_normalize_top dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(logic [1:0] op, logic [2:0] cnt, logic [15:0] x, y, z, w);
    in_valid <= 1;
    in_opcode <= op; in_component_count <= cnt;
    in_comp_x <= x; in_comp_y <= y; in_comp_z <= z; in_comp_w <= w;
    do @(posedge clk); while (in_stall);
    sb.note_vector(op, cnt, x, y, z, w);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_magnitude, out_norm_x, out_norm_y, out_norm_z, out_norm_w,
                       out_zero_vector});
  end

  // receiver back-pressure
  initial begin
    int n;
    int hold_done;
    hold_done = 0;
    @(posedge rst_n);
    while (1) begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_stall <= 1;
        repeat (120) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        n = gap_len();
        out_stall <= feeding && (n != 0);
        repeat (n == 0 ? $urandom_range(8, 1) : n) @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int lim;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // corners: extremes, every opcode, zero vector, counts out of range
    for (int op = 0; op < 4; op++) begin
      send_vector(2'(op), 3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_vector(2'(op), 3'd4, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_vector(2'(op), 3'd2, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
    end
    send_vector(vln_pkg::OP_NORMALISE, 3'd0, 16'h0003, 16'hfffc, 16'h1234, 16'h1234);
    send_vector(vln_pkg::OP_NORMALISE, 3'd1, 16'hffff, 16'h0000, 16'h1234, 16'h1234);
    send_vector(vln_pkg::OP_NORMALISE, 3'd7, 16'h0001, 16'h0001, 16'h0001, 16'hffff);
    send_vector(vln_pkg::OP_NORMALISE, 3'd5, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_vector(vln_pkg::OP_NORMALISE, 3'd3, 16'h0000, 16'h0000, 16'hffff, 16'h5555);
    send_vector(vln_pkg::OP_LENGTH, 3'd6, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    idle(1);
    hold_req++;
    for (int i = 0; i < 700; i++) begin
      if (i == 350) begin
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (i > 40 && $urandom_range(19) == 0) hold_req++;
      send_vector($urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2)),
                  $urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4, 2)),
                  pick_comp(), pick_comp(), pick_comp(), pick_comp());
      idle(gap_len());
    end
    in_valid <= 0;
    feeding = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    lim = 80;
    repeat (lim) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
rtl/vln_pkg.sv
rtl/vln_sumsq.sv
rtl/vln_isqrt.sv
rtl/vln_div.sv
rtl/vector_length_normalize_top.sv
bench/testbench.sv
